// File: src/tsce_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CORDIC angle table for the trigonometric
// series evaluator. No dependencies.
package tsce_pkg;

   localparam int MAX_TERMS_DEF    = 64;
   localparam int COEFF_BITS_DEF   = 32;
   localparam int CORDIC_STEPS_DEF = 28;

   localparam int ACC_W   = 48;   // Clenshaw accumulators, Q20.28
   localparam int TRIG_W  = 34;   // CORDIC datapath, Q1.30 with headroom
   localparam int MUL_A_W = 35;
   localparam int MUL_B_W = 50;
   localparam int MUL_H_W = 26;   // upper slice of operand b
   localparam int MUL_L_W = 24;   // lower slice of operand b
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int RES_W   = 57;

   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   localparam logic [2:0] CSR_ODD_MODE      = 3'd0;
   localparam logic [2:0] CSR_SYM_MODE      = 3'd1;
   localparam logic [2:0] CSR_TERM_COUNT    = 3'd2;
   localparam logic [2:0] CSR_ANGLE_SCALE   = 3'd3;
   localparam logic [2:0] CSR_SECULAR_SLOPE = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PHI_GO,
      ST_PHI_WAIT,
      ST_CORDIC_GO,
      ST_CORDIC_WAIT,
      ST_C2_GO,
      ST_C2_WAIT,
      ST_S2_GO,
      ST_S2_WAIT,
      ST_TERM_GO,
      ST_TERM_WAIT,
      ST_FIN_GO,
      ST_FIN_WAIT,
      ST_SEC_GO,
      ST_SEC_WAIT,
      ST_RESP
   } seq_state_type;

   // Rounded atan(2^-i) in binary angle units (2^32 is one turn).
   function automatic logic [31:0] cordic_atan(input int unsigned i);
      logic [31:0] v;
      begin
         case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
         endcase
         return v;
      end
   endfunction

endpackage

// File: src/tsce_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/tsce_mul.sv
`timescale 1ns / 1ps
// Shared multiplier: a 35 x 50 bit signed product built from two 35 x 26
// bit partial products, upper slice first. Depends on tsce_pkg.
module tsce_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [tsce_pkg::MUL_A_W-1:0] op_a,
   input  logic signed [tsce_pkg::MUL_B_W-1:0] op_b,
   output logic                                done,
   output logic signed [tsce_pkg::MUL_P_W-1:0] product
);
   import tsce_pkg::*;

   localparam int PP_W = MUL_A_W + MUL_H_W;

   logic signed [MUL_A_W-1:0] a_ff;
   logic signed [MUL_B_W-1:0] b_ff;
   logic        [1:0]         stage_ff, stage_in;
   logic signed [PP_W-1:0]    hi_ff, lo_ff, pp;
   logic signed [MUL_H_W-1:0] b_sel;
   logic signed [MUL_P_W-1:0] prod_ff;
   logic                      done_ff;

   // The upper slice is signed; the lower one is taken as unsigned.
   always_comb begin
      if (stage_ff == 2'd1) begin
         b_sel = b_ff[MUL_B_W-1:MUL_L_W];
      end else begin
         b_sel = $signed({{(MUL_H_W-MUL_L_W){1'b0}}, b_ff[MUL_L_W-1:0]});
      end
      pp = a_ff * b_sel;
      stage_in = stage_ff;
      if (start) begin
         stage_in = 2'd1;
      end else if (stage_ff != 2'd0) begin
         stage_in = (stage_ff == 2'd3) ? 2'd0 : stage_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= (stage_ff == 2'd3);
      end
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
      if (stage_ff == 2'd1) begin
         hi_ff <= pp;
      end
      if (stage_ff == 2'd2) begin
         lo_ff <= pp;
      end
      if (stage_ff == 2'd3) begin
         prod_ff <= (MUL_P_W'(hi_ff) <<< MUL_L_W) + MUL_P_W'(lo_ff);
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// File: src/tsce_cordic.sv
`timescale 1ns / 1ps
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, giving
// cosine and sine of a 32-bit binary angle in Q1.30. Depends on tsce_pkg.
module tsce_cordic #(
   parameter int CORDIC_STEPS = tsce_pkg::CORDIC_STEPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [31:0]                        phi,
   output logic                               done,
   output logic signed [tsce_pkg::TRIG_W-1:0] cos_out,
   output logic signed [tsce_pkg::TRIG_W-1:0] sin_out
);
   import tsce_pkg::*;

   localparam int IW = $clog2(CORDIC_STEPS + 1);

   logic                     busy_ff, done_ff, flip_ff;
   logic [IW-1:0]            iter_ff;
   logic signed [TRIG_W-1:0] x_ff, y_ff, z_ff, c_ff, s_ff;
   logic signed [TRIG_W-1:0] dx, dy, da;
   logic                     flip;
   logic [31:0]              phi_rot;

   always_comb begin
      // Second and third quadrants are folded by half a turn.
      flip    = (phi[31:30] == 2'b01) || (phi[31:30] == 2'b10);
      phi_rot = flip ? phi + 32'h8000_0000 : phi;
      dx      = y_ff >>> iter_ff;
      dy      = x_ff >>> iter_ff;
      da      = TRIG_W'(cordic_atan(int'(iter_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !start && busy_ff && (iter_ff == IW'(CORDIC_STEPS));
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && iter_ff == IW'(CORDIC_STEPS)) begin
            busy_ff <= 1'b0;
         end
      end
      if (start) begin
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= TRIG_W'($signed(phi_rot));
         flip_ff <= flip;
         iter_ff <= '0;
      end else if (busy_ff && iter_ff != IW'(CORDIC_STEPS)) begin
         if (z_ff >= 0) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - da;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + da;
         end
         iter_ff <= iter_ff + IW'(1);
      end else if (busy_ff) begin
         c_ff <= flip_ff ? -x_ff : x_ff;
         s_ff <= flip_ff ? -y_ff : y_ff;
      end
   end

   assign done    = done_ff;
   assign cos_out = c_ff;
   assign sin_out = s_ff;

endmodule

// File: src/trig_series_clenshaw_eval_core.sv
`timescale 1ns / 1ps
// Trigonometric series evaluator by Clenshaw's backward recurrence, one item at a time.
// A load leaves the core idle; a zero-term evaluate strobes its result in the next cycle.
// Otherwise it scales the position to an angle, runs the CORDIC, forms the double-angle
// products, makes one shared-multiplier pass per recurrence step and a final one, and adds
// the secular term for a plain sine series. The next item can be taken in the strobe cycle.
// The receiver cannot stall. Synchronous reset clears control and the CSRs, not the store.
module trig_series_clenshaw_eval_core #(
   parameter int MAX_TERMS    = tsce_pkg::MAX_TERMS_DEF,
   parameter int COEFF_BITS   = tsce_pkg::COEFF_BITS_DEF,
   parameter int CORDIC_STEPS = tsce_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [5:0]         req_coeff_index,
   input  logic signed [31:0] req_coeff_value,
   input  logic signed [31:0] req_position,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_series_value,
   output logic               rsp_saturated,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import tsce_pkg::*;

   localparam int AW       = $clog2(MAX_TERMS);
   localparam int CW       = $clog2(MAX_TERMS + 1);
   localparam int SAT_BITS = (COEFF_BITS < 32) ? COEFF_BITS : 32;
   localparam logic [31:0] LIM_MAX = 32'((64'd1 << (SAT_BITS - 1)) - 64'd1);
   localparam logic [31:0] LIM_MIN = ~LIM_MAX;
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   seq_state_type state_ff, state_in;

   logic                      odd_ff, sym_ff;
   logic [6:0]                term_count_ff;
   logic [31:0]               angle_scale_ff;
   logic signed [31:0]        slope_ff;

   logic signed [31:0]        pos_ff;
   logic [31:0]               phi_ff;
   logic signed [TRIG_W-1:0]  c_ff, s_ff;
   logic signed [MUL_A_W-1:0] c2_ff, s2_ff, x_ff;
   logic signed [ACC_W-1:0]   u0_ff, u1_ff;
   logic [CW-1:0]             k_ff;
   logic signed [RES_W-1:0]   res_ff;
   logic                      sat_ff;
   logic                      rsp_valid_ff, rsp_sat_ff;
   logic signed [31:0]        rsp_value_ff;

   logic                      mul_start, mul_done;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;
   logic signed [MUL_P_W-31:0] mul_q30;

   logic                      cordic_start, cordic_done;
   logic signed [TRIG_W-1:0]  cordic_c, cordic_s;

   logic                      accept, accept_load, accept_eval;
   logic [10:0]               tc_wide, m_wide, idx_wide;
   logic [CW-1:0]             k_dec, k_first;
   logic                      skip_zero, term_left;
   logic [31:0]               load_upper, load_value;
   logic                      ram_we, ram_re;
   logic [31:0]               ram_rdata;
   logic signed [RES_W-1:0]   t_sum, fin_val, res_next;
   logic signed [31:0]        res_clip;
   logic                      res_over;

   assign accept      = start && !busy;
   assign accept_load = accept && (req_command == REQ_LOAD);
   assign accept_eval = accept && (req_command == REQ_EVAL);

   always_comb begin
      tc_wide   = 11'(term_count_ff);
      m_wide    = (tc_wide > 11'(MAX_TERMS)) ? 11'(MAX_TERMS) : tc_wide;
      k_first   = m_wide[CW-1:0];
      k_dec     = k_ff - CW'(1);
      skip_zero = odd_ff && !sym_ff;
      term_left = k_ff > CW'(skip_zero);
      idx_wide  = 11'(req_coeff_index);
      // Loads saturate silently to COEFF_BITS, capped at 32 bits.
      load_upper = req_coeff_value >>> (SAT_BITS - 1);
      if (load_upper == '0 || load_upper == '1) begin
         load_value = req_coeff_value;
      end else begin
         load_value = req_coeff_value[31] ? LIM_MIN : LIM_MAX;
      end
      ram_we = accept_load && (idx_wide < 11'(MAX_TERMS));
      ram_re = (state_ff == ST_TERM_GO) && term_left;
   end

   tsce_ram #(
      .WIDTH(32),
      .DEPTH(MAX_TERMS)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(idx_wide[AW-1:0]),
      .wr_data(load_value),
      .rd_en  (ram_re),
      .rd_addr(k_dec[AW-1:0]),
      .rd_data(ram_rdata)
   );

   tsce_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .product(mul_p)
   );

   tsce_cordic #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .phi    (phi_ff),
      .done   (cordic_done),
      .cos_out(cordic_c),
      .sin_out(cordic_s)
   );

   assign mul_q30 = mul_p[MUL_P_W-1:30];

   // Operand selection for the shared multiplier, by sequencer step.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_PHI_GO: begin
            mul_a = MUL_A_W'(pos_ff);
            mul_b = $signed(MUL_B_W'(angle_scale_ff));
         end
         ST_C2_GO: begin
            mul_a = MUL_A_W'(c_ff) - MUL_A_W'(s_ff);
            mul_b = MUL_B_W'(MUL_A_W'(c_ff) + MUL_A_W'(s_ff));
         end
         ST_S2_GO: begin
            mul_a = MUL_A_W'(s_ff) <<< 1;
            mul_b = MUL_B_W'(c_ff);
         end
         ST_TERM_GO: begin
            mul_a = x_ff;
            mul_b = MUL_B_W'(u0_ff);
         end
         ST_FIN_GO: begin
            if (sym_ff && odd_ff) begin
               mul_a = MUL_A_W'(s_ff);
               mul_b = MUL_B_W'(u0_ff) + MUL_B_W'(u1_ff);
            end else if (sym_ff) begin
               mul_a = MUL_A_W'(c_ff);
               mul_b = MUL_B_W'(u0_ff) - MUL_B_W'(u1_ff);
            end else if (!odd_ff) begin
               mul_a = c2_ff;
               mul_b = MUL_B_W'(u1_ff);
            end else begin
               mul_a = s2_ff;
               mul_b = MUL_B_W'(u0_ff);
            end
         end
         ST_SEC_GO: begin
            mul_a = MUL_A_W'(pos_ff);
            mul_b = MUL_B_W'(slope_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      t_sum = RES_W'(mul_q30) - RES_W'(u1_ff) + RES_W'($signed(ram_rdata));
      if (!sym_ff && !odd_ff) begin
         fin_val = RES_W'(u0_ff) - RES_W'(mul_q30);
      end else begin
         fin_val = RES_W'(mul_q30);
      end
      res_next = res_ff + $signed(mul_p[RES_W+15:16]);
      res_over = (res_ff > RES_W'(32'sh7FFF_FFFF)) || (res_ff < -RES_W'(64'sh8000_0000));
      if (res_ff > RES_W'(32'sh7FFF_FFFF)) begin
         res_clip = 32'sh7FFF_FFFF;
      end else if (res_ff < -RES_W'(64'sh8000_0000)) begin
         res_clip = 32'sh8000_0000;
      end else begin
         res_clip = res_ff[31:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      mul_start    = 1'b0;
      cordic_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept_eval && m_wide != '0) begin
               state_in = ST_PHI_GO;
            end
         end
         ST_PHI_GO: begin
            mul_start = 1'b1;
            state_in  = ST_PHI_WAIT;
         end
         ST_PHI_WAIT: begin
            if (mul_done) begin
               state_in = ST_CORDIC_GO;
            end
         end
         ST_CORDIC_GO: begin
            cordic_start = 1'b1;
            state_in     = ST_CORDIC_WAIT;
         end
         ST_CORDIC_WAIT: begin
            if (cordic_done) begin
               state_in = ST_C2_GO;
            end
         end
         ST_C2_GO: begin
            mul_start = 1'b1;
            state_in  = ST_C2_WAIT;
         end
         ST_C2_WAIT: begin
            if (mul_done) begin
               state_in = ST_S2_GO;
            end
         end
         ST_S2_GO: begin
            mul_start = 1'b1;
            state_in  = ST_S2_WAIT;
         end
         ST_S2_WAIT: begin
            if (mul_done) begin
               state_in = ST_TERM_GO;
            end
         end
         ST_TERM_GO: begin
            if (term_left) begin
               mul_start = 1'b1;
               state_in  = ST_TERM_WAIT;
            end else begin
               state_in = ST_FIN_GO;
            end
         end
         ST_TERM_WAIT: begin
            if (mul_done) begin
               state_in = ST_TERM_GO;
            end
         end
         ST_FIN_GO: begin
            mul_start = 1'b1;
            state_in  = ST_FIN_WAIT;
         end
         ST_FIN_WAIT: begin
            if (mul_done) begin
               state_in = skip_zero ? ST_SEC_GO : ST_RESP;
            end
         end
         ST_SEC_GO: begin
            mul_start = 1'b1;
            state_in  = ST_SEC_WAIT;
         end
         ST_SEC_WAIT: begin
            if (mul_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         odd_ff         <= 1'b0;
         sym_ff         <= 1'b0;
         term_count_ff  <= '0;
         angle_scale_ff <= '0;
         slope_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         sat_ff         <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (accept_eval && m_wide == '0) || (state_ff == ST_RESP);
         if (csr_we) begin
            case (csr_index)
               CSR_ODD_MODE:      odd_ff         <= csr_wdata[0];
               CSR_SYM_MODE:      sym_ff         <= csr_wdata[0];
               CSR_TERM_COUNT:    term_count_ff  <= csr_wdata[6:0];
               CSR_ANGLE_SCALE:   angle_scale_ff <= csr_wdata;
               CSR_SECULAR_SLOPE: slope_ff       <= $signed(csr_wdata);
               default: begin
               end
            endcase
         end
         if (accept_eval) begin
            sat_ff <= 1'b0;
            if (m_wide == '0) begin
               rsp_value_ff <= '0;
               rsp_sat_ff   <= 1'b0;
            end
         end
         if (state_ff == ST_TERM_WAIT && mul_done &&
             (t_sum > RES_W'(ACC_MAX) || t_sum < RES_W'(ACC_MIN))) begin
            sat_ff <= 1'b1;
         end
         if (state_ff == ST_RESP) begin
            rsp_value_ff <= res_clip;
            rsp_sat_ff   <= sat_ff || res_over;
         end
      end
      if (accept_eval) begin
         pos_ff <= req_position;
         k_ff   <= k_first;
         u0_ff  <= '0;
         u1_ff  <= '0;
      end
      if (state_ff == ST_PHI_WAIT && mul_done) begin
         phi_ff <= mul_p[47:16];
      end
      if (cordic_done) begin
         c_ff <= cordic_c;
         s_ff <= cordic_s;
      end
      if (state_ff == ST_C2_WAIT && mul_done) begin
         c2_ff <= mul_q30[MUL_A_W-1:0];
         x_ff  <= mul_q30[MUL_A_W-1:0] <<< 1;
      end
      if (state_ff == ST_S2_WAIT && mul_done) begin
         s2_ff <= mul_q30[MUL_A_W-1:0];
      end
      if (state_ff == ST_TERM_WAIT && mul_done) begin
         u1_ff <= u0_ff;
         if (t_sum > RES_W'(ACC_MAX)) begin
            u0_ff <= ACC_MAX;
         end else if (t_sum < RES_W'(ACC_MIN)) begin
            u0_ff <= ACC_MIN;
         end else begin
            u0_ff <= t_sum[ACC_W-1:0];
         end
         k_ff <= k_dec;
      end
      if (state_ff == ST_FIN_WAIT && mul_done) begin
         res_ff <= fin_val;
      end
      if (state_ff == ST_SEC_WAIT && mul_done) begin
         res_ff <= res_next;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_series_value = rsp_value_ff;
   assign rsp_saturated    = rsp_sat_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while the sequencer is still working");

   a_eval_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept_eval && m_wide != '0) |=> busy)
      else $error("evaluate with terms did not start the sequencer");

   a_term_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TERM_WAIT) |-> (k_ff != '0))
      else $error("recurrence running with no term left");

   a_mul_done_waited: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_PHI_WAIT || state_ff == ST_C2_WAIT ||
                    state_ff == ST_S2_WAIT || state_ff == ST_TERM_WAIT ||
                    state_ff == ST_FIN_WAIT || state_ff == ST_SEC_WAIT))
      else $error("multiplier finished outside a wait step");

endmodule
